[hdl/fru_tl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_tl_pkg
// Shared types, codes and the bcd plus character table of the fru
// type/length field decoder.
// ----------------------------------------------------------------------------
package fru_tl_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TYPE_W   = 2;
    localparam int unsigned NRES     = 4;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned M_DATA_W = 16;

    // field types
    localparam logic [TYPE_W-1:0] TY_BINARY = 2'd0;
    localparam logic [TYPE_W-1:0] TY_BCD    = 2'd1;
    localparam logic [TYPE_W-1:0] TY_ASCII6 = 2'd2;
    localparam logic [TYPE_W-1:0] TY_ASCII8 = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_CHAR   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BINARY = 2'd2;

    localparam logic [BYTE_W-1:0] ASCII6_BASE = 8'h20;

    typedef struct packed {
        logic [CNT_W-1:0]             count;
        logic [NRES-1:0][BYTE_W-1:0]  chars;
        logic [STATUS_W-1:0]          status;
        logic                         eof;
    } t_bundle;

    function automatic logic [BYTE_W-1:0] bcd_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] c;
        begin
            case (nib)
                4'd0:    c = 8'h30;
                4'd1:    c = 8'h31;
                4'd2:    c = 8'h32;
                4'd3:    c = 8'h33;
                4'd4:    c = 8'h34;
                4'd5:    c = 8'h35;
                4'd6:    c = 8'h36;
                4'd7:    c = 8'h37;
                4'd8:    c = 8'h38;
                4'd9:    c = 8'h39;
                4'd10:   c = 8'h20;
                4'd11:   c = 8'h2D;
                4'd12:   c = 8'h2E;
                4'd13:   c = 8'h3A;
                4'd14:   c = 8'h2C;
                default: c = 8'h5F;
            endcase
            return c;
        end
    endfunction

endpackage

[hdl/fru_type_length_field_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_type_length_field_decoder
// Decodes ipmi fru type/length fields into a stream of ascii characters and status results.
// ----------------------------------------------------------------------------
// One fru area byte is taken per cycle while the result register can take
// the bundle it produces. Results leave one per cycle from that register
// while the output is ready: bcd plus and 8-bit ascii bytes give one result,
// a type/length byte with a zero count or binary type gives one status
// result, other header bytes, binary data bytes and held 6-bit ascii bytes
// give none, and each completed 6-bit group gives four. The output port
// carries one result at a time, and the next byte is taken in the cycle the
// last result of the previous one is handed over.
module fru_type_length_field_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // field_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // char_code, last_of_item, zero fill
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast    // end_of_field
);

    logic                 space;
    logic                 accept;
    logic                 load;
    fru_tl_pkg::t_bundle  bundle;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    fru_tl_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_start  (s_axis_tuser),
        .o_load   (load),
        .o_bundle (bundle)
    );

    fru_tl_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_bundle      (bundle),
        .o_space       (space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[hdl/fru_tl_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_tl_decode
// Field tracking state and per-byte decode into a bundle of up to four
// results.
// ----------------------------------------------------------------------------
module fru_tl_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [fru_tl_pkg::BYTE_W-1:0] i_byte,
    input  logic                          i_start,
    output logic                          o_load,
    output fru_tl_pkg::t_bundle           o_bundle
);

    logic                            r_expect, n_expect;
    logic [fru_tl_pkg::TYPE_W-1:0]   r_type, n_type;
    logic [fru_tl_pkg::LEN_W-1:0]    r_left, n_left;
    logic [15:0]                     r_group, n_group;
    logic [1:0]                      r_gcnt, n_gcnt;
    logic                            r_skip, n_skip;

    logic                            hdr;
    logic [fru_tl_pkg::LEN_W-1:0]    left_m;
    logic                            eof;
    logic [23:0]                     v;
    fru_tl_pkg::t_bundle             bnd;

    assign hdr    = i_start || r_expect || (r_left == '0);
    assign left_m = r_left - fru_tl_pkg::LEN_W'(1);
    assign eof    = (left_m == '0);

    always_comb begin
        case (r_gcnt)
            2'd0:    v = {16'd0, i_byte};
            2'd1:    v = {8'd0, i_byte, r_group[7:0]};
            default: v = {i_byte, r_group};
        endcase
    end

    always_comb begin
        n_expect   = r_expect;
        n_type     = r_type;
        n_left     = r_left;
        n_group    = r_group;
        n_gcnt     = r_gcnt;
        n_skip     = r_skip;
        bnd        = '0;
        bnd.status = fru_tl_pkg::ST_CHAR;
        if (hdr) begin
            n_type  = i_byte[7:6];
            n_left  = i_byte[5:0];
            n_group = '0;
            n_gcnt  = '0;
            n_skip  = 1'b0;
            if (i_byte[5:0] == '0) begin
                n_expect   = 1'b1;
                bnd.count  = fru_tl_pkg::CNT_W'(1);
                bnd.status = fru_tl_pkg::ST_EMPTY;
                bnd.eof    = 1'b1;
            end else if (i_byte[7:6] == fru_tl_pkg::TY_BINARY) begin
                n_expect   = 1'b0;
                n_skip     = 1'b1;
                bnd.count  = fru_tl_pkg::CNT_W'(1);
                bnd.status = fru_tl_pkg::ST_BINARY;
                bnd.eof    = 1'b1;
            end else begin
                n_expect = 1'b0;
            end
        end else begin
            n_left = left_m;
            if (r_skip) begin
                bnd.count = '0;
            end else if (r_type == fru_tl_pkg::TY_BCD) begin
                bnd.count    = fru_tl_pkg::CNT_W'(1);
                bnd.chars[0] = fru_tl_pkg::bcd_char(i_byte[3:0]);
                bnd.eof      = eof;
            end else if (r_type == fru_tl_pkg::TY_ASCII8) begin
                bnd.count    = fru_tl_pkg::CNT_W'(1);
                bnd.chars[0] = i_byte;
                bnd.eof      = eof;
            end else if ((r_gcnt < 2'd2) && !eof) begin
                // hold partial 6-bit group
                if (r_gcnt == 2'd0) begin
                    n_group[7:0] = i_byte;
                end else begin
                    n_group[15:8] = i_byte;
                end
                n_gcnt = r_gcnt + 2'd1;
            end else begin
                bnd.count = fru_tl_pkg::CNT_W'(fru_tl_pkg::NRES);
                for (int i = 0; i < fru_tl_pkg::NRES; i++) begin
                    bnd.chars[i] = {2'b00, v[6*i +: 6]} + fru_tl_pkg::ASCII6_BASE;
                end
                bnd.eof = eof;
                n_group = '0;
                n_gcnt  = '0;
            end
            if (eof) begin
                n_expect = 1'b1;
                n_skip   = 1'b0;
                n_group  = '0;
                n_gcnt   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect <= 1'b1;
            r_type   <= '0;
            r_left   <= '0;
            r_group  <= '0;
            r_gcnt   <= '0;
            r_skip   <= 1'b0;
        end else if (i_accept) begin
            r_expect <= n_expect;
            r_type   <= n_type;
            r_left   <= n_left;
            r_group  <= n_group;
            r_gcnt   <= n_gcnt;
            r_skip   <= n_skip;
        end
    end

    assign o_load   = i_accept && (bnd.count != '0);
    assign o_bundle = bnd;

endmodule

[hdl/fru_tl_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_tl_emit
// Result register holding one decoded bundle, handed out one result per
// cycle on the output stream while the stream is ready.
// ----------------------------------------------------------------------------
module fru_tl_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  fru_tl_pkg::t_bundle             i_bundle,
    output logic                            o_space,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fru_tl_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic [fru_tl_pkg::STATUS_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast
);

    logic                           r_valid;
    logic [fru_tl_pkg::IDX_W-1:0]   r_idx;
    fru_tl_pkg::t_bundle            r_bnd;
    logic                           at_last;
    logic                           done;

    assign at_last = ({1'b0, r_idx} == (r_bnd.count - fru_tl_pkg::CNT_W'(1)));
    assign done    = r_valid && m_axis_tready && at_last;
    assign o_space = !r_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (done) begin
            r_valid <= 1'b0;
        end else if (r_valid && m_axis_tready) begin
            r_idx <= r_idx + fru_tl_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bnd <= i_bundle;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, at_last, r_bnd.chars[r_idx]};
    assign m_axis_tuser  = r_bnd.status;
    assign m_axis_tlast  = r_bnd.eof && at_last;

endmodule

[hdl/fru_tl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_tl_checker
// Port-level checks on the output stream of the fru type/length decoder.
// ----------------------------------------------------------------------------
module fru_tl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == fru_tl_pkg::ST_CHAR ||
                           m_axis_tuser == fru_tl_pkg::ST_EMPTY ||
                           m_axis_tuser == fru_tl_pkg::ST_BINARY))
        else $error("undefined status code");

    a_status_zero_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != fru_tl_pkg::ST_CHAR)
            |-> (m_axis_tdata[7:0] == 8'd0) && m_axis_tlast && m_axis_tdata[8])
        else $error("status item not a lone closing item with zero char");

    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[8])
        else $error("end of field not on last item of its byte");

endmodule

bind fru_type_length_field_decoder fru_tl_checker u_fru_tl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
